// ----- sv/fbse_pkg.sv -----
// ----------------------------------------------------------------------------
// Frame buffer scroll engine package
// Command codes, the blank pixel value and default frame dimensions.
// ----------------------------------------------------------------------------
`default_nettype none

package fbse_pkg;

  localparam int DEF_WIDTH  = 128;
  localparam int DEF_HEIGHT = 128;

  localparam int PIX_W = 8;
  localparam int CMD_W = 3;

  localparam logic [PIX_W-1:0] BLANK_PIXEL = 8'hff;

  localparam logic [CMD_W-1:0] CMD_SET     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_FILL    = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SHIFT_H = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SHIFT_V = 3'd4;

endpackage

`default_nettype wire

// ----- sv/frame_buffer_scroll_engine.sv -----
// Set and get take one beat per cycle while in_stall is low; a get result appears the cycle after its beat.
// Fill writes every pixel of the store, one store write per cycle.
// A horizontal or vertical shift sweeps the image line by line,
// paced by the single read port and single write port of the frame store.
// After reset the store is swept to 0xff while in_stall is held high.
// ----------------------------------------------------------------------------
// Frame buffer scroll engine
// Pixel store with set, get, fill and one-pixel shift of the whole image.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_buffer_scroll_engine #(
  parameter int WIDTH  = fbse_pkg::DEF_WIDTH,
  parameter int HEIGHT = fbse_pkg::DEF_HEIGHT
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [fbse_pkg::CMD_W-1:0]  in_cmd,
  input  wire logic [7:0]                  in_x_coord,
  input  wire logic [7:0]                  in_y_coord,
  input  wire logic [fbse_pkg::PIX_W-1:0]  in_pixel_value,
  input  wire logic                        in_toward_low,
  input  wire logic                        in_wrap,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [fbse_pkg::PIX_W-1:0]       out_read_value,
  output logic                             out_in_range
);

  localparam int NPIX = WIDTH * HEIGHT;
  localparam int AW   = $clog2(NPIX);
  localparam int MAXD = (WIDTH > HEIGHT) ? WIDTH : HEIGHT;
  localparam int LW   = $clog2(MAXD);
  localparam int SW   = $clog2(MAXD + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FILL  = 2'd1;
  localparam logic [1:0] ST_SHIFT = 2'd2;

  localparam logic [AW-1:0] WIDTH_A   = AW'(WIDTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NPIX - 1);

  logic [fbse_pkg::PIX_W-1:0] mem [NPIX];

  logic [1:0]                 state_r, state_nxt;
  logic [AW-1:0]              fill_addr_r, fill_addr_nxt;
  logic [fbse_pkg::PIX_W-1:0] fill_val_r, fill_val_nxt;
  logic [LW-1:0]              line_r, line_nxt;
  logic [SW-1:0]              step_r, step_nxt;
  logic                       vert_r, vert_nxt;
  logic                       low_r, low_nxt;
  logic                       wrap_r, wrap_nxt;
  logic                       st2_wr_r, st2_wr_nxt;
  logic                       st2_cap_r, st2_cap_nxt;
  logic                       st2_mem_r;
  logic [AW-1:0]              st2_addr_r;
  logic [fbse_pkg::PIX_W-1:0] hold_r;
  logic [fbse_pkg::PIX_W-1:0] rd_data_r;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_in_range_r;

  logic                       in_accept;
  logic                       in_frame;
  logic [AW-1:0]              pix_addr;
  logic                       shifting;
  logic                       step_last;
  logic                       line_last;
  logic [AW-1:0]              pos;
  logic [AW-1:0]              major;
  logic [AW-1:0]              minor;
  logic [AW-1:0]              sweep_addr;
  logic [AW-1:0]              stride;
  logic [AW-1:0]              st2_wr_addr;
  logic [fbse_pkg::PIX_W-1:0] st2_wr_data;

  logic                       mem_we;
  logic [AW-1:0]              mem_wa;
  logic [fbse_pkg::PIX_W-1:0] mem_wd;
  logic                       mem_re;
  logic [AW-1:0]              mem_ra;

  assign in_stall  = (state_r != ST_IDLE) | st2_wr_r | st2_cap_r | (out_valid_r & out_stall);
  assign in_accept = in_valid & ~in_stall;

  assign in_frame = ({1'b0, in_x_coord} < 9'(WIDTH)) && ({1'b0, in_y_coord} < 9'(HEIGHT));
  assign pix_addr = AW'(in_y_coord) * WIDTH_A + AW'(in_x_coord);

  // Each line (a row, or a column for vertical shifts) takes length+1 steps.
  // Step 0 reads the pixel that leaves the line, middle steps copy one pixel
  // per step, and the last step writes the vacated edge. Addresses wrap
  // modulo 2**AW so the virtual position past either end still lands right
  // after the one-pixel write offset.
  assign shifting  = (state_r == ST_SHIFT);
  assign step_last = vert_r ? (step_r == SW'(HEIGHT)) : (step_r == SW'(WIDTH));
  assign line_last = vert_r ? (line_r == LW'(WIDTH - 1)) : (line_r == LW'(HEIGHT - 1));

  always_comb begin
    if (low_r) begin
      pos = AW'(step_r);
    end else if (vert_r) begin
      pos = AW'(HEIGHT - 1) - AW'(step_r);
    end else begin
      pos = AW'(WIDTH - 1) - AW'(step_r);
    end
  end

  assign major      = vert_r ? pos : AW'(line_r);
  assign minor      = vert_r ? AW'(line_r) : pos;
  assign sweep_addr = major * WIDTH_A + minor;

  assign stride      = vert_r ? WIDTH_A : AW'(1);
  assign st2_wr_addr = low_r ? (st2_addr_r - stride) : (st2_addr_r + stride);
  assign st2_wr_data = st2_mem_r ? rd_data_r : (wrap_r ? hold_r : fbse_pkg::BLANK_PIXEL);

  always_comb begin
    state_nxt     = state_r;
    fill_addr_nxt = fill_addr_r;
    fill_val_nxt  = fill_val_r;
    line_nxt      = line_r;
    step_nxt      = step_r;
    vert_nxt      = vert_r;
    low_nxt       = low_r;
    wrap_nxt      = wrap_r;
    st2_wr_nxt    = shifting & (step_r != '0);
    st2_cap_nxt   = shifting & (step_r == '0);
    out_valid_nxt = out_valid_r & out_stall;
    mem_we        = 1'b0;
    mem_wa        = pix_addr;
    mem_wd        = in_pixel_value;
    mem_re        = 1'b0;
    mem_ra        = pix_addr;

    unique case (state_r)
      ST_FILL: begin
        mem_we        = 1'b1;
        mem_wa        = fill_addr_r;
        mem_wd        = fill_val_r;
        fill_addr_nxt = fill_addr_r + AW'(1);
        if (fill_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        mem_re = ~step_last;
        mem_ra = sweep_addr;
        if (step_last) begin
          step_nxt = '0;
          line_nxt = line_r + LW'(1);
          if (line_last) begin
            state_nxt = ST_IDLE;
          end
        end else begin
          step_nxt = step_r + SW'(1);
        end
      end
      default: begin
      end
    endcase

    if (st2_wr_r) begin
      mem_we = 1'b1;
      mem_wa = st2_wr_addr;
      mem_wd = st2_wr_data;
    end

    if (in_accept) begin
      unique case (in_cmd) inside
        fbse_pkg::CMD_SET: begin
          mem_we = in_frame;
        end
        fbse_pkg::CMD_GET: begin
          mem_re        = in_frame;
          out_valid_nxt = 1'b1;
        end
        fbse_pkg::CMD_FILL: begin
          state_nxt     = ST_FILL;
          fill_addr_nxt = '0;
          fill_val_nxt  = in_pixel_value;
        end
        fbse_pkg::CMD_SHIFT_H, fbse_pkg::CMD_SHIFT_V: begin
          state_nxt = ST_SHIFT;
          line_nxt  = '0;
          step_nxt  = '0;
          vert_nxt  = (in_cmd == fbse_pkg::CMD_SHIFT_V);
          low_nxt   = in_toward_low;
          wrap_nxt  = in_wrap;
        end
        default: begin
        end
      endcase
    end
  end

  // Frame store: one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_ra];
    end
  end

  always_ff @(posedge clk) begin
    st2_mem_r  <= ~step_last;
    st2_addr_r <= sweep_addr;
    if (st2_cap_r) begin
      hold_r <= rd_data_r;
    end
    if (in_accept && (in_cmd == fbse_pkg::CMD_GET)) begin
      out_in_range_r <= in_frame;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_FILL;
      fill_addr_r <= '0;
      fill_val_r  <= fbse_pkg::BLANK_PIXEL;
      line_r      <= '0;
      step_r      <= '0;
      vert_r      <= 1'b0;
      low_r       <= 1'b0;
      wrap_r      <= 1'b0;
      st2_wr_r    <= 1'b0;
      st2_cap_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_val_r  <= fill_val_nxt;
      line_r      <= line_nxt;
      step_r      <= step_nxt;
      vert_r      <= vert_nxt;
      low_r       <= low_nxt;
      wrap_r      <= wrap_nxt;
      st2_wr_r    <= st2_wr_nxt;
      st2_cap_r   <= st2_cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_in_range   = out_in_range_r;
  assign out_read_value = out_in_range_r ? rd_data_r : fbse_pkg::BLANK_PIXEL;

endmodule

`default_nettype wire
